[rtl/sfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants and types of the sensor frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int FRAME_BYTES = 28;
  localparam int STORE_DEPTH = 2 * FRAME_BYTES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int POS_W       = $clog2(FRAME_BYTES);

  localparam logic [7:0] HDR1_RESET = 8'h5A;
  localparam logic [7:0] HDR2_RESET = 8'hA5;
  localparam logic [7:0] SUM_GOOD   = 8'hFF;

  // register indexes of the configuration port
  localparam logic REG_FIRST_HDR  = 1'b0;
  localparam logic REG_SECOND_HDR = 1'b1;

  // frame layout
  localparam int SEQ_BYTE    = 2;
  localparam int WORD_BASE   = 3;
  localparam int STATUS_BASE = 25;
  localparam int WORD_COUNT  = 11;
  localparam int LAST_FIELD  = 12;
  localparam int FIELD_IDX_W = 4;

  // one finished frame handed from the front to the back
  typedef struct packed {
    logic       ok;
    logic [7:0] seq;
    logic       bank;
  } cmd_t;

  // write port of the frame store
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  function automatic logic [ADDR_W-1:0] store_addr(input logic bank,
                                                   input logic [POS_W-1:0] pos);
    logic [ADDR_W-1:0] base;
    base = bank ? ADDR_W'(FRAME_BYTES) : '0;
    return base + ADDR_W'(pos);
  endfunction

endpackage

[rtl/sfd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_front
// Header hunter: checks sync bytes, tracks position and checksum, writes
// body bytes into the frame store and queues one command per frame.
// ----------------------------------------------------------------------------
module sfd_front import sfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  input  logic [7:0] rx_byte_i,
  input  logic       q_full_i,
  output logic       in_stall_o,
  output logic       push_o,
  output cmd_t       cmd_o,
  output wr_t        wr_o
);

  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;

  logic [7:0]       hdr1_q, hdr2_q;
  logic [1:0]       ph_q, ph_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       seq_q, seq_d;
  logic             bank_q, bank_d;
  logic [7:0]       sum_add;
  logic             accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign sum_add    = sum_q + rx_byte_i;

  always_comb begin
    ph_d      = ph_q;
    pos_d     = pos_q;
    sum_d     = sum_q;
    seq_d     = seq_q;
    bank_d    = bank_q;
    push_o    = 1'b0;
    wr_o.en   = 1'b0;
    wr_o.addr = store_addr(bank_q, pos_q);
    wr_o.data = rx_byte_i;
    cmd_o.ok   = (sum_add == SUM_GOOD);
    cmd_o.seq  = seq_q;
    cmd_o.bank = bank_q;
    if (accept) begin
      unique case (ph_q)
        PH_SECOND: begin
          if (rx_byte_i == hdr2_q) begin
            sum_d = sum_add;
            pos_d = POS_W'(SEQ_BYTE);
            ph_d  = PH_BODY;
          end else begin
            // the mismatching byte is dropped, not checked as a first header
            ph_d = PH_HUNT;
          end
        end
        PH_BODY: begin
          wr_o.en = 1'b1;
          if (pos_q == POS_W'(SEQ_BYTE)) begin
            seq_d = rx_byte_i;
          end
          if (pos_q == POS_W'(FRAME_BYTES - 1)) begin
            push_o = 1'b1;
            ph_d   = PH_HUNT;
            sum_d  = '0;
            pos_d  = '0;
            bank_d = ~bank_q;
          end else begin
            sum_d = sum_add;
            pos_d = pos_q + POS_W'(1);
          end
        end
        default: begin
          if (rx_byte_i == hdr1_q) begin
            sum_d = rx_byte_i;
            ph_d  = PH_SECOND;
          end else begin
            ph_d = PH_HUNT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr1_q <= HDR1_RESET;
      hdr2_q <= HDR2_RESET;
      ph_q   <= PH_HUNT;
      pos_q  <= '0;
      sum_q  <= '0;
      seq_q  <= '0;
      bank_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_index_i == REG_FIRST_HDR) begin
        hdr1_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == REG_SECOND_HDR) begin
        hdr2_q <= cfg_data_i;
      end
      ph_q   <= ph_d;
      pos_q  <= pos_d;
      sum_q  <= sum_d;
      seq_q  <= seq_d;
      bank_q <= bank_d;
    end
  end

endmodule

[rtl/sfd_cmd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_cmd_queue
// Two-entry queue of frame commands; an entry stays until the back
// has finished reading its bank of the frame store.
// ----------------------------------------------------------------------------
module sfd_cmd_queue import sfd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t head_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

[rtl/sfd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_back
// Frame store and readout sequencer: turns each queued frame into its
// run of field results, or one error result on a bad checksum.
// ----------------------------------------------------------------------------
module sfd_back import sfd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wr_t                    wr_i,
  input  logic                   q_valid_i,
  input  cmd_t                   q_head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   frame_ok_o,
  output logic [FIELD_IDX_W-1:0] field_index_o,
  output logic [15:0]            field_value_o,
  output logic [7:0]             sequence_number_o,
  output logic                   last_o
);

  localparam logic [1:0] B_IDLE    = 2'd0;
  localparam logic [1:0] B_WAIT_HI = 2'd1;
  localparam logic [1:0] B_WAIT_LO = 2'd2;
  localparam logic [1:0] B_EMIT    = 2'd3;

  logic [7:0]             mem [STORE_DEPTH];
  logic [7:0]             rd_data_q;
  logic                   rd_en;
  logic [POS_W-1:0]       rd_pos;
  logic [1:0]             st_q, st_d;
  logic [FIELD_IDX_W-1:0] idx_q, idx_d;
  logic [7:0]             hi_q, hi_d;
  logic [15:0]            val_q, val_d;
  logic                   out_free;
  logic                   load_out;
  logic                   is_last;

  // frame byte that holds the high (or only) byte of a field, or the low byte
  function automatic logic [POS_W-1:0] field_byte(input logic [FIELD_IDX_W-1:0] k,
                                                  input logic lo_half);
    logic [POS_W-1:0] kp;
    kp = POS_W'(k);
    if (k < FIELD_IDX_W'(WORD_COUNT)) begin
      return POS_W'(WORD_BASE) + (kp << 1) + POS_W'(lo_half);
    end
    return POS_W'(STATUS_BASE) + kp - POS_W'(WORD_COUNT);
  endfunction

  assign out_free = !out_valid_o || !out_stall_i;
  assign is_last  = !q_head_i.ok || (idx_q == FIELD_IDX_W'(LAST_FIELD));

  always_comb begin
    st_d     = st_q;
    idx_d    = idx_q;
    hi_d     = hi_q;
    val_d    = val_q;
    rd_en    = 1'b0;
    rd_pos   = field_byte(idx_q, 1'b0);
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (st_q)
      B_IDLE: begin
        if (q_valid_i) begin
          if (q_head_i.ok) begin
            rd_en = 1'b1;
            st_d  = B_WAIT_HI;
          end else begin
            st_d = B_EMIT;
          end
        end
      end
      B_WAIT_HI: begin
        if (idx_q < FIELD_IDX_W'(WORD_COUNT)) begin
          hi_d   = rd_data_q;
          rd_en  = 1'b1;
          rd_pos = field_byte(idx_q, 1'b1);
          st_d   = B_WAIT_LO;
        end else begin
          val_d = {8'h00, rd_data_q};
          st_d  = B_EMIT;
        end
      end
      B_WAIT_LO: begin
        val_d = {hi_q, rd_data_q};
        st_d  = B_EMIT;
      end
      default: begin
        if (out_free) begin
          load_out = 1'b1;
          if (is_last) begin
            pop_o = 1'b1;
            idx_d = '0;
            st_d  = B_IDLE;
          end else begin
            idx_d  = idx_q + FIELD_IDX_W'(1);
            rd_en  = 1'b1;
            rd_pos = field_byte(idx_q + FIELD_IDX_W'(1), 1'b0);
            st_d   = B_WAIT_HI;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en) begin
      rd_data_q <= mem[store_addr(q_head_i.bank, rd_pos)];
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q  <= hi_d;
    val_q <= val_d;
    if (load_out) begin
      frame_ok_o        <= q_head_i.ok;
      field_index_o     <= q_head_i.ok ? idx_q : '0;
      field_value_o     <= q_head_i.ok ? val_q : '0;
      sequence_number_o <= q_head_i.seq;
      last_o            <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      idx_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      st_q  <= st_d;
      idx_q <= idx_d;
      if (load_out) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule

[rtl/sensor_frame_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_deframer
// Receives serial bytes, finds two-byte-header frames, checks the sum and
// reads each good frame out as thirteen field results.
// ----------------------------------------------------------------------------
// input channel: one rx byte per transfer (in_valid_i / in_stall_o); a byte
//   is taken while valid and not stalled, the front stalls only while two
//   finished frames are held in the command queue
// config channel: cfg_index_i 0 = first header byte, 1 = second header byte;
//   always ready, write only while the block is idle
// output channel: one result per transfer (out_valid_o / out_stall_i), held
//   in an output register; a good frame gives 13 results, a bad sum gives
//   one result with frame_ok_o low, last_o marks the end of the run
// readout starts once a frame's command is queued; a word field takes two
//   reads of the single-read-port frame store (B_WAIT_HI, B_WAIT_LO), a
//   status byte one (B_WAIT_HI), before the result goes out from B_EMIT
// the store holds two frames, so the next frame is collected during readout
// a stalled receiver holds the current result and the readout waits
// reset: hunting for the first header, header bytes 0x5A / 0xA5, queue empty
// ----------------------------------------------------------------------------
module sensor_frame_deframer import sfd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_index_i,
  input  logic [7:0]             cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             rx_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   frame_ok_o,
  output logic [FIELD_IDX_W-1:0] field_index_o,
  output logic [15:0]            field_value_o,
  output logic [7:0]             sequence_number_o,
  output logic                   last_o
);

  logic push, pop, q_full, q_valid;
  cmd_t cmd, head;
  wr_t  wr;

  assign cfg_ready_o = 1'b1;

  sfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .rx_byte_i   (rx_byte_i),
    .q_full_i    (q_full),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .cmd_o       (cmd),
    .wr_o        (wr)
  );

  sfd_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (head)
  );

  sfd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .wr_i              (wr),
    .q_valid_i         (q_valid),
    .q_head_i          (head),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .frame_ok_o        (frame_ok_o),
    .field_index_o     (field_index_o),
    .field_value_o     (field_value_o),
    .sequence_number_o (sequence_number_o),
    .last_o            (last_o)
  );

endmodule

[verif/sensor_frame_deframer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_deframer_test
// Self-checking bench for the deframer. Byte streams of good frames, bad
// sums, broken headers and line noise go in under several header settings
// and idle/stall mixes; every result is checked against an in-bench model.
// ----------------------------------------------------------------------------
module sensor_frame_deframer_test import sfd_pkg::*; ();

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic [1:0] {SEEK_FIRST, SEEK_SECOND, IN_BODY} sync_state_e;
  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_HEADERS} fill_e;

  typedef struct packed {
    logic                   ok;
    logic [FIELD_IDX_W-1:0] idx;
    logic [15:0]            value;
    logic [7:0]             seq;
    logic                   last;
  } field_t;

  logic                   clk_i;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic                   cfg_index_i = REG_FIRST_HDR;
  logic [7:0]             cfg_data_i  = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic [7:0]             rx_byte_i   = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic                   frame_ok_o;
  logic [FIELD_IDX_W-1:0] field_index_o;
  logic [15:0]            field_value_o;
  logic [7:0]             sequence_number_o;
  logic                   last_o;

  sensor_frame_deframer dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .frame_ok_o        (frame_ok_o),
    .field_index_o     (field_index_o),
    .field_value_o     (field_value_o),
    .sequence_number_o (sequence_number_o),
    .last_o            (last_o)
  );

  // deframer state as the bench sees it
  logic [7:0]  hdr_first  = HDR1_RESET;
  logic [7:0]  hdr_second = HDR2_RESET;
  sync_state_e sync_state = SEEK_FIRST;
  int          frame_pos  = 0;
  logic [7:0]  frame_sum  = '0;
  logic [7:0]  frame_bytes [FRAME_BYTES];

  field_t      pending_fields [$];
  logic [7:0]  tx_frame [FRAME_BYTES];

  int idle_pct      = 0;
  int stall_pct     = 0;
  int bytes_sent    = 0;
  int good_frames   = 0;
  int bad_frames    = 0;
  int fields_seen   = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(negedge clk_i) out_stall_i <= ($urandom_range(0, 99) < stall_pct);

  task automatic push_field(input logic ok, input logic [FIELD_IDX_W-1:0] idx,
                            input logic [15:0] value, input logic [7:0] seq,
                            input logic last);
    field_t f;
    f.ok    = ok;
    f.idx   = idx;
    f.value = value;
    f.seq   = seq;
    f.last  = last;
    pending_fields.push_back(f);
  endtask

  // advance the sync state by one received byte, queue any fields it completes
  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] seq;
    int         i;
    case (sync_state)
      SEEK_SECOND: begin
        if (b == hdr_second) begin
          frame_bytes[1] = b;
          frame_sum      = frame_sum + b;
          frame_pos      = 2;
          sync_state     = IN_BODY;
        end else begin
          sync_state = SEEK_FIRST;
        end
      end
      IN_BODY: begin
        frame_bytes[frame_pos] = b;
        frame_sum              = frame_sum + b;
        frame_pos++;
        if (frame_pos == FRAME_BYTES) begin
          sync_state = SEEK_FIRST;
          frame_pos  = 0;
          seq        = frame_bytes[SEQ_BYTE];
          if (frame_sum != SUM_GOOD) begin
            push_field(1'b0, '0, '0, seq, 1'b1);
            bad_frames++;
          end else begin
            for (i = 0; i < WORD_COUNT; i++)
              push_field(1'b1, FIELD_IDX_W'(i),
                         {frame_bytes[WORD_BASE + 2 * i], frame_bytes[WORD_BASE + 2 * i + 1]},
                         seq, 1'b0);
            push_field(1'b1, FIELD_IDX_W'(WORD_COUNT), {8'h00, frame_bytes[STATUS_BASE]},
                       seq, 1'b0);
            push_field(1'b1, FIELD_IDX_W'(LAST_FIELD), {8'h00, frame_bytes[STATUS_BASE + 1]},
                       seq, 1'b1);
            good_frames++;
          end
          frame_sum = '0;
        end
      end
      default: begin
        sync_state = SEEK_FIRST;
        if (b == hdr_first) begin
          frame_bytes[0] = b;
          frame_sum      = b;
          frame_pos      = 1;
          sync_state     = SEEK_SECOND;
        end
      end
    endcase
  endtask

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    rx_byte_i  = b;
    do @(posedge clk_i); while (in_stall_o);
    deframe_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic fill_frame(input fill_e pattern, input logic [7:0] seq);
    int i;
    for (i = SEQ_BYTE + 1; i < FRAME_BYTES - 1; i++) begin
      case (pattern)
        FILL_ZERO:    tx_frame[i] = 8'h00;
        FILL_ONES:    tx_frame[i] = 8'hFF;
        FILL_HEADERS: tx_frame[i] = i[0] ? hdr_first : hdr_second;
        default:      tx_frame[i] = 8'($urandom);
      endcase
    end
    tx_frame[SEQ_BYTE] = seq;
  endtask

  // add headers and the closing sum byte, then send the whole frame
  task automatic send_frame(input logic good_sum);
    logic [7:0] s;
    int         i;
    tx_frame[0] = hdr_first;
    tx_frame[1] = hdr_second;
    s = '0;
    for (i = 0; i < FRAME_BYTES - 1; i++) s = s + tx_frame[i];
    tx_frame[FRAME_BYTES - 1] = SUM_GOOD - s;
    if (!good_sum) tx_frame[FRAME_BYTES - 1] += 8'($urandom_range(1, 255));
    for (i = 0; i < FRAME_BYTES; i++) send_byte(tx_frame[i]);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending_fields.size() != 0) @(negedge clk_i);
    // a partial frame may still be in the front, let it settle
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_FIRST_HDR) hdr_first = data;
    else                      hdr_second = data;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_headers(input logic [7:0] first, input logic [7:0] second);
    wait_drained();
    write_reg(REG_FIRST_HDR, first);
    write_reg(REG_SECOND_HDR, second);
  endtask

  task automatic test_field_extremes();
    fill_frame(FILL_ZERO, 8'h00);
    send_frame(1'b1);
    fill_frame(FILL_ONES, 8'hFF);
    send_frame(1'b1);
  endtask

  task automatic test_bad_sum();
    fill_frame(FILL_RANDOM, 8'h5C);
    send_frame(1'b0);
  endtask

  // a wrong byte after the first header is dropped, even if it is a first header
  task automatic test_broken_header();
    send_byte(hdr_first);
    send_byte(hdr_first);
    send_byte(hdr_second);
    send_byte(hdr_first);
    send_byte(hdr_second ^ 8'h01);
    fill_frame(FILL_RANDOM, 8'h81);
    send_frame(1'b1);
  endtask

  task automatic test_headers_in_body();
    fill_frame(FILL_HEADERS, hdr_first);
    send_frame(1'b1);
  endtask

  task automatic test_header_registers();
    set_headers(8'h00, 8'hFF);
    fill_frame(FILL_RANDOM, 8'h01);
    send_frame(1'b1);
    // equal header bytes: a repeated header completes the sync
    set_headers(8'h3C, 8'h3C);
    send_byte(8'h3C);
    test_headers_in_body();
  endtask

  task automatic test_random_traffic(input int idle, input int stall);
    int start;
    int r;
    int n;
    set_headers(8'($urandom), 8'($urandom));
    idle_pct  = idle;
    stall_pct = stall;
    start     = bytes_sent;
    while (bytes_sent < start + 20) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        fill_frame(FILL_RANDOM, 8'($urandom));
        send_frame(1'b1);
      end else if (r < 75) begin
        fill_frame(FILL_RANDOM, 8'($urandom));
        send_frame(1'b0);
      end else if (r < 85) begin
        send_byte(hdr_first);
        send_byte(8'($urandom));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom));
      end
    end
    wait_drained();
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    field_t got;
    field_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {frame_ok_o, field_index_o, field_value_o, sequence_number_o, last_o};
      fields_seen++;
      if (pending_fields.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: ok=%0b idx=%0d value=%h seq=%h last=%0b",
                   got.ok, got.idx, got.value, got.seq, got.last);
      end else begin
        want = pending_fields.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch: exp ok=%0b idx=%0d value=%h seq=%h last=%0b",
                      " / got ok=%0b idx=%0d value=%h seq=%h last=%0b"},
                     want.ok, want.idx, want.value, want.seq, want.last,
                     got.ok, got.idx, got.value, got.seq, got.last);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, pending_fields.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed cases run with no idling
    test_field_extremes();
    test_bad_sum();
    test_broken_header();
    test_header_registers();
    test_random_traffic(50, 0);
    test_random_traffic(0, 50);
    test_random_traffic(37, 37);
    wait_drained();

    if (pending_fields.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", pending_fields.size());
    end
    $display("sent %0d bytes: %0d good frames, %0d bad sums, %0d results checked",
             bytes_sent, good_frames, bad_frames, fields_seen);
    $display("header settings and idle/stall mixes swept, %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/sfd_pkg.sv
rtl/sfd_front.sv
rtl/sfd_cmd_queue.sv
rtl/sfd_back.sv
rtl/sensor_frame_deframer.sv
verif/sensor_frame_deframer_test.sv
